FILE: hw/rtl/abrms_pkg.sv
package abrms_pkg;

  // Sample and result widths
  localparam int SAMPLE_W = 16;
  localparam int ROOT_W   = 16;
  localparam int SQ_W     = 31;   // a squared 16-bit magnitude fits in 31 bits

  // Configuration register file
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int LEN_CFG_W  = 11;
  localparam logic [CFG_ADDR_W-1:0] ADDR_BLOCK_LEN  = 3'd0;
  localparam logic [LEN_CFG_W-1:0]  BLOCK_LEN_RESET = 11'd160;

  // Back-end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQRT,
    BK_HOLD
  } bk_state_t;

endpackage

FILE: hw/rtl/abrms_fifo.sv
module abrms_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Store the incoming request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/abrms_front.sv
module abrms_front
  import abrms_pkg::*;
#(
  parameter int LEN_W = 11,
  parameter int SUM_W = 41
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic [LEN_W-1:0]           len,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  logic                       q_full,
  output logic                       push,
  output logic [SUM_W-1:0]           push_sum,
  output logic [LEN_W-1:0]           push_len,
  output logic signed [SAMPLE_W-1:0] push_min,
  output logic signed [SAMPLE_W-1:0] push_max
);

  logic [LEN_W-1:0]           cnt_r;
  logic [SUM_W-1:0]           sum_r;
  logic [SQ_W-1:0]            sq_r;
  logic                       sq_vld_r;
  logic                       close_r;
  logic signed [SAMPLE_W-1:0] min_r, max_r;

  logic                       accept;
  logic [SAMPLE_W-1:0]        mag;
  logic [2*SAMPLE_W-1:0]      sq_full;
  logic [LEN_W-1:0]           cnt_inc;
  logic [SUM_W-1:0]           sum_add;

  // Hold off while a closing block waits to be queued or the queue is full
  assign in_ready = !close_r && !q_full;
  assign accept   = in_valid && in_ready;

  // Square the magnitude; the register splits multiply from accumulate
  assign mag     = in_sample[SAMPLE_W-1] ? (~in_sample + 1'b1) : in_sample;
  assign sq_full = mag * mag;
  assign cnt_inc = cnt_r + 1'b1;
  assign sum_add = sum_r + SUM_W'(sq_r);

  // Queue the finished block in the cycle after its last sample
  assign push     = close_r;
  assign push_sum = sum_add;
  assign push_len = len;
  assign push_min = min_r;
  assign push_max = max_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      sq_r <= sq_full[SQ_W-1:0];
    end
  end

  // Track block extremes; the first sample of a block loads both
  always_ff @(posedge clk) begin
    if (accept) begin
      if (cnt_r == '0) begin
        min_r <= in_sample;
        max_r <= in_sample;
      end else begin
        if (in_sample < min_r) min_r <= in_sample;
        if (in_sample > max_r) max_r <= in_sample;
      end
    end
  end

  // Count samples, accumulate squares, flag block close
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      sum_r    <= '0;
      sq_vld_r <= 1'b0;
      close_r  <= 1'b0;
    end else if (clr) begin
      cnt_r    <= '0;
      sum_r    <= '0;
      sq_vld_r <= 1'b0;
      close_r  <= 1'b0;
    end else begin
      sq_vld_r <= accept;
      if (close_r) begin
        sum_r <= '0;
      end else if (sq_vld_r) begin
        sum_r <= sum_add;
      end
      close_r <= 1'b0;
      if (accept) begin
        if (cnt_inc >= len) begin
          cnt_r   <= '0;
          close_r <= 1'b1;
        end else begin
          cnt_r <= cnt_inc;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/abrms_back.sv
module abrms_back
  import abrms_pkg::*;
#(
  parameter int LEN_W = 11,
  parameter int SUM_W = 41
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  output logic                       pop,
  input  logic [SUM_W-1:0]           q_sum,
  input  logic [LEN_W-1:0]           q_len,
  input  logic signed [SAMPLE_W-1:0] q_min,
  input  logic signed [SAMPLE_W-1:0] q_max,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [ROOT_W-1:0]          out_rms_level,
  output logic signed [SAMPLE_W-1:0] out_min_sample,
  output logic signed [SAMPLE_W-1:0] out_max_sample
);

  localparam int STEP_W = $clog2(SUM_W);

  bk_state_t                  state_r, state_nxt;
  logic [SUM_W-1:0]           dvd_r, dvd_nxt;
  logic [LEN_W-1:0]           rem_r, rem_nxt;
  logic [LEN_W-1:0]           dsr_r, dsr_nxt;
  logic [STEP_W-1:0]          step_r, step_nxt;
  logic [ROOT_W-1:0]          root_r, root_nxt;
  logic [ROOT_W-1:0]          bit_r, bit_nxt;
  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]          out_rms_r, out_rms_nxt;
  logic signed [SAMPLE_W-1:0] out_min_r, out_min_nxt;
  logic signed [SAMPLE_W-1:0] out_max_r, out_max_nxt;

  logic [LEN_W:0]             trial_rem;
  logic [ROOT_W-1:0]          trial_root;
  logic [2*ROOT_W-1:0]        trial_sq;

  assign out_valid      = out_valid_r;
  assign out_rms_level  = out_rms_r;
  assign out_min_sample = out_min_r;
  assign out_max_sample = out_max_r;

  // One restoring-divide step and one square-root trial per cycle
  assign trial_rem  = {rem_r, dvd_r[SUM_W-1]};
  assign trial_root = root_r | bit_r;
  assign trial_sq   = trial_root * trial_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    dsr_r     <= dsr_nxt;
    step_r    <= step_nxt;
    root_r    <= root_nxt;
    bit_r     <= bit_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    out_rms_r <= out_rms_nxt;
    out_min_r <= out_min_nxt;
    out_max_r <= out_max_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    step_nxt      = step_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    out_rms_nxt   = out_rms_r;
    out_min_nxt   = out_min_r;
    out_max_nxt   = out_max_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pop           = 1'b0;

    unique case (state_r)
      // Take the next block request from the queue
      BK_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          dvd_nxt   = q_sum;
          rem_nxt   = '0;
          dsr_nxt   = q_len;
          step_nxt  = STEP_W'(SUM_W - 1);
          min_nxt   = q_min;
          max_nxt   = q_max;
          state_nxt = BK_DIV;
        end
      end
      // Shift quotient bits into the dividend register
      BK_DIV: begin
        if (trial_rem >= {1'b0, dsr_r}) begin
          rem_nxt = LEN_W'(trial_rem - {1'b0, dsr_r});
          dvd_nxt = {dvd_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial_rem[LEN_W-1:0];
          dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          root_nxt  = '0;
          bit_nxt   = {1'b1, {(ROOT_W-1){1'b0}}};
          state_nxt = BK_SQRT;
        end
      end
      // Keep each root bit whose square stays within the mean
      BK_SQRT: begin
        if (trial_sq <= {1'b0, dvd_r[SQ_W-1:0]}) begin
          root_nxt = trial_root;
        end
        bit_nxt = bit_r >> 1;
        if (bit_r[0]) begin
          state_nxt = BK_HOLD;
        end
      end
      // Load the output register once it is free
      BK_HOLD: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_rms_nxt   = root_r;
          out_min_nxt   = min_r;
          out_max_nxt   = max_r;
          state_nxt     = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

endmodule

FILE: hw/rtl/audio_block_rms_meter.sv
// Block RMS level meter for a stream of signed 16-bit PCM samples.
// Samples enter on in_valid/in_ready, one per cycle while in_ready is
// high. Every block of block_len samples (0 acts as 1, values above
// MAX_BLOCK saturate) yields one result on out_valid/out_ready: the floor
// square root of the floored mean square, plus the block's smallest and
// largest sample. The front accumulates squares and extremes at one
// sample per cycle while the queue has room, and holds off input in the
// cycle after a block's last sample to queue the block. The back divides
// bit-serially (one quotient bit per cycle over the sum width, 41 bits at
// MAX_BLOCK = 1024) and then finds the 16-bit root bit by bit. It takes a
// new block only after loading the last one's result; a 2-entry queue
// between front and back absorbs short blocks before in_ready drops.
// block_len is written through the cfg_ APB port at address 0; a write
// drops the block in progress. Reset sets block_len to 160 and clears
// all accumulators. When the receiver stalls, the result holds in the
// output register, the back waits with the next one, and the queue fills
// until the front stops taking samples.
module audio_block_rms_meter
  import abrms_pkg::*;
#(
  parameter int MAX_BLOCK = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [CFG_DATA_W-1:0]        cfg_prdata,
  output logic                         cfg_pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [SAMPLE_W-1:0]   in_sample,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ROOT_W-1:0]            out_rms_level,
  output logic signed [SAMPLE_W-1:0]   out_min_sample,
  output logic signed [SAMPLE_W-1:0]   out_max_sample
);

  localparam int LEN_W   = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W   = SQ_W + $clog2(MAX_BLOCK);
  localparam int CMP_W   = (LEN_W > LEN_CFG_W) ? LEN_W : LEN_CFG_W;
  localparam int ENTRY_W = SUM_W + LEN_W + 2 * SAMPLE_W;
  localparam int Q_DEPTH = 2;

  logic [LEN_CFG_W-1:0]       block_len_r;
  logic                       cfg_wr;
  logic [CMP_W-1:0]           len_ext;
  logic [LEN_W-1:0]           eff_len;

  logic                       push, q_full, q_valid, pop;
  logic [SUM_W-1:0]           push_sum, q_sum;
  logic [LEN_W-1:0]           push_len, q_len;
  logic signed [SAMPLE_W-1:0] push_min, push_max, q_min, q_max;
  logic [ENTRY_W-1:0]         push_data, pop_data;

  // Register write and readback
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                      (cfg_paddr == ADDR_BLOCK_LEN);
  assign cfg_prdata = (cfg_paddr == ADDR_BLOCK_LEN) ?
                      CFG_DATA_W'(block_len_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= BLOCK_LEN_RESET;
    end else if (cfg_wr) begin
      block_len_r <= cfg_pwdata[LEN_CFG_W-1:0];
    end
  end

  // Clamp the block length to 1..MAX_BLOCK
  assign len_ext = CMP_W'(block_len_r);
  always_comb begin
    priority if (len_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (len_ext > CMP_W'(MAX_BLOCK)) begin
      eff_len = LEN_W'(MAX_BLOCK);
    end else begin
      eff_len = LEN_W'(len_ext);
    end
  end

  abrms_front #(
    .LEN_W (LEN_W),
    .SUM_W (SUM_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (cfg_wr),
    .len       (eff_len),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_sample (in_sample),
    .q_full    (q_full),
    .push      (push),
    .push_sum  (push_sum),
    .push_len  (push_len),
    .push_min  (push_min),
    .push_max  (push_max)
  );

  assign push_data = {push_sum, push_len, push_min, push_max};
  assign {q_sum, q_len, q_min, q_max} = pop_data;

  abrms_fifo #(
    .DATA_W (ENTRY_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .pop_data  (pop_data)
  );

  abrms_back #(
    .LEN_W (LEN_W),
    .SUM_W (SUM_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .pop            (pop),
    .q_sum          (q_sum),
    .q_len          (q_len),
    .q_min          (q_min),
    .q_max          (q_max),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rms_level  (out_rms_level),
    .out_min_sample (out_min_sample),
    .out_max_sample (out_max_sample)
  );

endmodule
